// ----- rtl/core/hires_artifact_row_renderer_core_assert.svh -----
// assertion macros for the row renderer checker
// depends on nothing; included by the checker file only
`ifndef HIRES_ARTIFACT_ROW_RENDERER_CORE_ASSERT_SVH
`define HIRES_ARTIFACT_ROW_RENDERER_CORE_ASSERT_SVH

// same-cycle implication
`define HRAR_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("hrar assertion failed");

// next-cycle implication
`define HRAR_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("hrar assertion failed");

`endif

// ----- rtl/core/hrar_pkg.sv -----
// shared types and constants of the hires artifact row renderer
// depends on nothing
package hrar_pkg;

    localparam int ROW_BYTES   = 40;
    localparam int POS_W       = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [2:0] PIX_BLACK = 3'd0;
    localparam logic [2:0] PAL_PLUS  = 3'd4;

    typedef enum logic [1:0] {
        JOB_BLACK  = 2'b01,
        JOB_RENDER = 2'b10
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] cur;
        logic       nxt_bit0;
        logic       nxt_pal;
        logic       odd;
        logic       left;
        logic       mono;
        logic       run_last;
        logic       row_last;
    } job_t;

    typedef struct packed {
        logic first;
        logic second;
    } job_push_t;

endpackage

// ----- rtl/core/hrar_front.sv -----
// front part: takes frame bytes, tracks row position and lookahead, issues jobs
// depends on hrar_pkg
module hrar_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         frame_byte,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               q_full,
    output hrar_pkg::job_push_t job_push,
    output hrar_pkg::job_t     job_a,
    output hrar_pkg::job_t     job_b
);
    import hrar_pkg::*;

    logic             mono_reg, mono_next;
    logic [7:0]       held_reg, held_next;
    logic             left_reg, left_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             accept;
    logic             row_start;
    logic             row_end;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;
    assign row_start = (pos_reg == '0);
    assign row_end   = (pos_reg >= POS_W'(ROW_BYTES - 1));

    always_comb
    begin
        mono_next = mono_reg;
        if (cfg_valid && cfg_ready)
        begin
            mono_next = cfg_data;
        end
    end

    always_comb
    begin
        job_a          = '0;
        job_b          = '0;
        job_push       = '0;
        held_next      = held_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        job_a.kind     = JOB_BLACK;
        job_b.kind     = JOB_RENDER;
        job_a.mono     = mono_reg;
        job_b.mono     = mono_reg;
        job_a.run_last = 1'b1;
        if (row_start)
        begin
            job_push.first = accept && frame_byte[7];
            if (accept)
            begin
                held_next = frame_byte;
                left_next = 1'b0;
                pos_next  = POS_W'(1);
            end
        end
        else
        begin
            job_a.kind     = JOB_RENDER;
            job_a.cur      = held_reg;
            job_a.nxt_bit0 = frame_byte[0];
            job_a.nxt_pal  = frame_byte[7];
            job_a.odd      = ~pos_reg[0];
            job_a.left     = left_reg;
            job_a.run_last = !row_end;
            // final byte of the row sees a zero byte after it
            job_b.cur      = frame_byte;
            job_b.odd      = pos_reg[0];
            job_b.left     = held_reg[6];
            job_b.run_last = 1'b1;
            job_b.row_last = 1'b1;
            job_push.first  = accept;
            job_push.second = accept && row_end;
            if (accept)
            begin
                if (row_end)
                begin
                    held_next = '0;
                    left_next = 1'b0;
                    pos_next  = '0;
                end
                else
                begin
                    held_next = frame_byte;
                    left_next = held_reg[6];
                    pos_next  = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg <= 1'b0;
            held_reg <= '0;
            left_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            mono_reg <= mono_next;
            held_reg <= held_next;
            left_reg <= left_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ----- rtl/core/hrar_job_queue.sv -----
// short job queue between front and back, takes up to two jobs per cycle
// depends on hrar_pkg
module hrar_job_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  hrar_pkg::job_push_t job_push,
    input  hrar_pkg::job_t      job_a,
    input  hrar_pkg::job_t      job_b,
    output logic                q_full,
    output logic                head_valid,
    output hrar_pkg::job_t      head,
    input  logic                head_pop
);
    import hrar_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QPTR_W-1:0] wr_plus;

    assign wr_plus    = wr_reg + QPTR_W'(1);
    assign q_full     = (cnt_reg > QCNT_W'(QUEUE_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(job_push.first) + QPTR_W'(job_push.second);
        rd_next  = rd_reg + QPTR_W'(head_pop);
        cnt_next = cnt_reg + QCNT_W'(job_push.first) + QCNT_W'(job_push.second)
                 - QCNT_W'(head_pop);
    end

    always_ff @(posedge clk)
    begin
        if (job_push.first)
        begin
            entry_reg[wr_reg] <= job_a;
        end
        if (job_push.second)
        begin
            entry_reg[wr_plus] <= job_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/hrar_back.sv -----
// back part: walks each job pixel by pixel into the result register
// depends on hrar_pkg
module hrar_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  hrar_pkg::job_t head,
    output logic           head_pop,
    output logic           empty,
    input  logic           pop,
    output logic [2:0]     pixel_index,
    output logic           run_last,
    output logic           row_last
);
    import hrar_pkg::*;

    function automatic logic [1:0] classify(input logic [2:0] w, input logic odd);
        logic [1:0] c;
        begin
            case (w)
                3'b011, 3'b110, 3'b111: c = 2'd1;
                3'b010:                 c = {1'b1, odd};
                3'b101:                 c = {1'b1, ~odd};
                default:                c = 2'd0;
            endcase
            return c;
        end
    endfunction

    logic [2:0] j_reg, j_next;
    logic [1:0] rep_reg, rep_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] pix_reg;
    logic       run_reg;
    logic       row_reg;
    logic [8:0] bits;
    logic [2:0] win;
    logic [1:0] pal;
    logic [1:0] last_rep;
    logic [2:0] base;
    logic [2:0] pix;
    logic       job_done;
    logic       out_take;
    logic       advance;

    assign bits     = {head.nxt_bit0, head.cur[6:0], head.left};
    assign win      = 3'(bits >> j_reg);
    assign pal      = {head.nxt_pal, head.cur[7]};
    assign out_take = pop && out_valid_reg;
    assign advance  = head_valid && (!out_valid_reg || out_take);

    always_comb
    begin
        last_rep = 2'd1;
        if (j_reg == 3'd6)
        begin
            case (pal)
                2'b01:   last_rep = 2'd0;
                2'b10:   last_rep = 2'd2;
                default: last_rep = 2'd1;
            endcase
        end
        if (head.mono)
        begin
            base = {2'b00, head.cur[j_reg]};
        end
        else
        begin
            base = {head.cur[7], classify(win, head.odd ^ j_reg[0])};
        end
        pix = base;
        if (rep_reg == 2'd2 && !head.mono)
        begin
            pix = base | PAL_PLUS;
        end
        if (head.kind == JOB_BLACK)
        begin
            pix = PIX_BLACK;
        end
        job_done = (head.kind == JOB_BLACK) || (j_reg == 3'd6 && rep_reg == last_rep);
    end

    always_comb
    begin
        j_next         = j_reg;
        rep_next       = rep_reg;
        head_pop       = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (job_done)
            begin
                j_next   = '0;
                rep_next = '0;
                head_pop = 1'b1;
            end
            else if (rep_reg == last_rep)
            begin
                j_next   = j_reg + 3'd1;
                rep_next = '0;
            end
            else
            begin
                rep_next = rep_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg <= pix;
            run_reg <= job_done && head.run_last;
            row_reg <= job_done && head.row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg         <= '0;
            rep_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            j_reg         <= j_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign pixel_index = pix_reg;
    assign run_last    = run_reg;
    assign row_last    = row_reg;

endmodule

// ----- rtl/core/hires_artifact_row_renderer_core.sv -----
// top level of the hires artifact row renderer
// depends on hrar_pkg, hrar_front, hrar_job_queue, hrar_back
//
// Each frame byte yields zero to 29 double-width pixels, and the block
// delivers one pixel per cycle from its result register while pop takes
// each one, so a byte gives 13 to 15 pixels mid-row, up to 29 for the last
// byte of a row and none or one for the first; the pixel walker in the back
// part sets these numbers. Bytes are accepted one per cycle as long as the
// four-entry job queue has room for two jobs, so full shows only back
// pressure from the pixel side. The mono register (mono_reg) is written
// through cfg_valid and cfg_data and is always ready.
module hires_artifact_row_renderer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] frame_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] pixel_index,
    output logic       run_last,
    output logic       row_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import hrar_pkg::*;

    job_push_t job_push;
    job_t      job_a;
    job_t      job_b;
    job_t      head;
    logic      q_full;
    logic      head_valid;
    logic      head_pop;

    hrar_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .frame_byte (frame_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .job_push   (job_push),
        .job_a      (job_a),
        .job_b      (job_b)
    );

    hrar_job_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_push   (job_push),
        .job_a      (job_a),
        .job_b      (job_b),
        .q_full     (q_full),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    hrar_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .head_pop    (head_pop),
        .empty       (empty),
        .pop         (pop),
        .pixel_index (pixel_index),
        .run_last    (run_last),
        .row_last    (row_last)
    );

endmodule

// ----- rtl/core/hrar_checker.sv -----
// port-level checks of the row renderer, bound to the top level
// depends on hires_artifact_row_renderer_core_assert.svh
`include "hires_artifact_row_renderer_core_assert.svh"

module hrar_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [2:0] pixel_index,
    input logic       run_last,
    input logic       row_last
);

    // end of a row always closes the item's run
    `HRAR_ASSERT_NOW(a_row_closes_run, clk, rst_n, !empty && row_last, run_last)
    // full only rises after a byte came in
    `HRAR_ASSERT_NOW(a_full_after_push, clk, rst_n, $rose(full), $past(push))
    // results only drain by being taken
    `HRAR_ASSERT_NOW(a_empty_after_pop, clk, rst_n, $rose(empty), $past(pop))
    // a waiting result holds
    `HRAR_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop,
        !empty && $stable(pixel_index) && $stable(run_last) && $stable(row_last))

endmodule

bind hires_artifact_row_renderer_core hrar_checker u_hrar_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .pixel_index (pixel_index),
    .run_last    (run_last),
    .row_last    (row_last)
);
